/* rtl/pcs_pkg.sv */
// Shared constants and the sum snapshot type of the correlation screen.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pcs_pkg;

   localparam int NumFeatures = 8;
   localparam int SampleWidth = 16;
   localparam int SumWidth    = 33;
   localparam int SqWidth     = 48;
   localparam int CountWidth  = 17;
   localparam int IndexWidth  = 3;
   localparam int CfgWidth    = 4;
   localparam int MulWidth    = 64;
   localparam int ProdWidth   = 128;
   localparam int DenWidth    = 125;
   localparam int QuotWidth   = 31;
   localparam int DivWidth    = DenWidth + QuotWidth - 1;
   localparam int StepWidth   = 5;
   localparam int RootSteps   = 16;

   typedef struct packed {
      logic [NumFeatures-1:0][SumWidth-1:0] fsum;
      logic [NumFeatures-1:0][SqWidth-1:0]  fsq;
      logic [NumFeatures-1:0][SqWidth-1:0]  xsum;
      logic [SumWidth-1:0]                  ysum;
      logic [SqWidth-1:0]                   ysq;
      logic [CountWidth-1:0]                count;
   } snap_type;

endpackage

`default_nettype wire

/* rtl/pearson_correlation_screen_top.sv */
// Rows are taken one per clock while busy is low; busy is high only while a finished data set
// waits for the back end; the back end takes it as soon as it is idle, later when the previous
// set is still out. The back end runs on one bit-serial multiplier: two products per data
// set, then per feature six products, 31 division steps and 16 root steps, or four products
// where a variance is zero; one result per strobe, the receiver cannot stall. Synchronous
// reset clears the row sums and sets 8 features. Depends on pcs_pkg, pcs_front and pcs_back.
`default_nettype none

module pearson_correlation_screen_top (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]   req_response_sample,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]   req_feature_0,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]   req_feature_1,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]   req_feature_2,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]   req_feature_3,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]   req_feature_4,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]   req_feature_5,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]   req_feature_6,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]   req_feature_7,
   input  wire logic                                     req_final_row,
   output logic                                          rsp_strobe,
   output logic [pcs_pkg::IndexWidth-1:0]                rsp_feature_index,
   output logic signed [pcs_pkg::SampleWidth-1:0]        rsp_correlation,
   output logic                                          rsp_last_feature,
   input  wire logic                                     csr_write_enable,
   input  wire logic [pcs_pkg::CfgWidth-1:0]             csr_write_data
);

   logic [pcs_pkg::CfgWidth-1:0] cfg_ff;
   logic [pcs_pkg::NumFeatures-1:0][pcs_pkg::SampleWidth-1:0] features;
   logic take, snap_valid;
   pcs_pkg::snap_type snap;

   assign features = {req_feature_7, req_feature_6, req_feature_5, req_feature_4,
                      req_feature_3, req_feature_2, req_feature_1, req_feature_0};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pcs_pkg::CfgWidth'(pcs_pkg::NumFeatures);
      end else if (csr_write_enable) begin
         cfg_ff <= csr_write_data;
      end
   end

   pcs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .response_sample (req_response_sample),
      .features        (features),
      .final_row       (req_final_row),
      .take            (take),
      .busy            (busy),
      .snap_valid      (snap_valid),
      .snap            (snap)
   );

   pcs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .snap_valid      (snap_valid),
      .snap            (snap),
      .features_in_use (cfg_ff),
      .take            (take),
      .strobe          (rsp_strobe),
      .feature_index   (rsp_feature_index),
      .correlation     (rsp_correlation),
      .last_feature    (rsp_last_feature)
   );

endmodule

`default_nettype wire

/* rtl/pcs_front.sv */
// Front of the correlation screen: row accumulators and the one-deep snapshot queue.
// Depends on pcs_pkg.
`default_nettype none

module pcs_front (
   input  wire logic                                                  clock,
   input  wire logic                                                  reset,
   input  wire logic                                                  start,
   input  wire logic signed [pcs_pkg::SampleWidth-1:0]                response_sample,
   input  wire logic [pcs_pkg::NumFeatures-1:0][pcs_pkg::SampleWidth-1:0] features,
   input  wire logic                                                  final_row,
   input  wire logic                                                  take,
   output logic                                                       busy,
   output logic                                                       snap_valid,
   output pcs_pkg::snap_type                                          snap
);

   pcs_pkg::snap_type acc_ff, acc_in, acc_upd, snap_ff, snap_in;
   logic snap_valid_ff, snap_valid_in;
   logic signed [2*pcs_pkg::SampleWidth-1:0] yy;
   logic signed [2*pcs_pkg::SampleWidth-1:0] xx [pcs_pkg::NumFeatures];
   logic signed [2*pcs_pkg::SampleWidth-1:0] xy [pcs_pkg::NumFeatures];
   logic signed [pcs_pkg::SampleWidth-1:0]   xs [pcs_pkg::NumFeatures];
   logic accept;

   assign busy       = snap_valid_ff;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;
   assign accept     = start && !snap_valid_ff;

   always_comb begin
      yy = response_sample * response_sample;
      for (int j = 0; j < pcs_pkg::NumFeatures; j++) begin
         xs[j] = $signed(features[j]);
         xx[j] = xs[j] * xs[j];
         xy[j] = xs[j] * response_sample;
      end
   end

   always_comb begin
      acc_upd = acc_ff;
      if (!acc_ff.count[pcs_pkg::CountWidth-1]) begin
         acc_upd.ysum  = acc_ff.ysum + pcs_pkg::SumWidth'(response_sample);
         acc_upd.ysq   = acc_ff.ysq + pcs_pkg::SqWidth'($unsigned(yy));
         acc_upd.count = acc_ff.count + 1'b1;
         for (int j = 0; j < pcs_pkg::NumFeatures; j++) begin
            acc_upd.fsum[j] = acc_ff.fsum[j] + pcs_pkg::SumWidth'(xs[j]);
            acc_upd.fsq[j]  = acc_ff.fsq[j] + pcs_pkg::SqWidth'($unsigned(xx[j]));
            acc_upd.xsum[j] = acc_ff.xsum[j] + pcs_pkg::SqWidth'(xy[j]);
         end
      end
   end

   always_comb begin
      acc_in        = acc_ff;
      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff && !take;
      if (accept) begin
         if (final_row) begin
            acc_in        = '0;
            snap_in       = acc_upd;
            snap_valid_in = 1'b1;
         end else begin
            acc_in = acc_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

endmodule

`default_nettype wire

/* rtl/pcs_mul.sv */
// Bit-serial signed 64 by 64 multiplier, one multiplier bit per cycle.
// Depends on pcs_pkg.
`default_nettype none

module pcs_mul (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                go,
   input  wire logic signed [pcs_pkg::MulWidth-1:0] op_a,
   input  wire logic signed [pcs_pkg::MulWidth-1:0] op_b,
   output logic                                     done,
   output logic [pcs_pkg::ProdWidth-1:0]            product
);

   localparam int CntWidth = $clog2(pcs_pkg::MulWidth);
   localparam logic [CntWidth-1:0] LastStep = CntWidth'(pcs_pkg::MulWidth - 1);

   logic run_ff, done_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic [pcs_pkg::ProdWidth-1:0] acc_ff, mcand_ff, term, acc_in;
   logic [pcs_pkg::MulWidth-1:0] mplier_ff;

   assign done    = done_ff;
   assign product = acc_ff;

   always_comb begin
      term   = mplier_ff[0] ? mcand_ff : '0;
      acc_in = (cnt_ff == LastStep) ? acc_ff - term : acc_ff + term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go && !run_ff) begin
            run_ff    <= 1'b1;
            cnt_ff    <= '0;
            acc_ff    <= '0;
            mcand_ff  <= pcs_pkg::ProdWidth'(op_a);
            mplier_ff <= op_b;
         end else if (run_ff) begin
            acc_ff    <= acc_in;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            cnt_ff    <= cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/pcs_back.sv */
// Back of the correlation screen: per-feature sequencer, long division and square root.
// Depends on pcs_pkg and pcs_mul.
`default_nettype none

module pcs_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                snap_valid,
   input  wire pcs_pkg::snap_type                   snap,
   input  wire logic [pcs_pkg::CfgWidth-1:0]        features_in_use,
   output logic                                     take,
   output logic                                     strobe,
   output logic [pcs_pkg::IndexWidth-1:0]           feature_index,
   output logic signed [pcs_pkg::SampleWidth-1:0]   correlation,
   output logic                                     last_feature
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_YN   = 4'd1;
   localparam logic [3:0] S_YS   = 4'd2;
   localparam logic [3:0] S_XN   = 4'd3;
   localparam logic [3:0] S_XS   = 4'd4;
   localparam logic [3:0] S_CN   = 4'd5;
   localparam logic [3:0] S_CS   = 4'd6;
   localparam logic [3:0] S_CHK  = 4'd7;
   localparam logic [3:0] S_DEN  = 4'd8;
   localparam logic [3:0] S_NUM  = 4'd9;
   localparam logic [3:0] S_DIV  = 4'd10;
   localparam logic [3:0] S_ROOT = 4'd11;
   localparam logic [3:0] S_EMIT = 4'd12;

   localparam int MW = pcs_pkg::MulWidth;
   localparam int SW = pcs_pkg::SampleWidth;
   localparam int QW = pcs_pkg::QuotWidth;
   localparam logic [pcs_pkg::StepWidth-1:0] DivLast  = pcs_pkg::StepWidth'(QW - 1);
   localparam logic [pcs_pkg::StepWidth-1:0] RootLast = pcs_pkg::StepWidth'(pcs_pkg::RootSteps - 1);
   localparam logic [pcs_pkg::CfgWidth-1:0]  CfgMax   = pcs_pkg::CfgWidth'(pcs_pkg::NumFeatures);
   localparam logic [SW-1:0] CorrMax = {1'b0, {(SW-1){1'b1}}};

   logic [3:0] state_ff;
   pcs_pkg::snap_type work_ff;
   logic [pcs_pkg::IndexWidth-1:0] idx_ff, last_ff, last_in;
   logic wait_ff, mul_state, mul_go, mul_done;
   logic signed [MW-1:0] op_a, op_b;
   logic [pcs_pkg::ProdWidth-1:0] product;
   logic [MW-1:0] t1_ff, syy_ff, sxx_ff, sxy_ff, plo, mag;
   logic [pcs_pkg::DivWidth-1:0] rem_ff, dsh_ff;
   logic [QW-1:0] quo_ff, root_ff, bit_ff, trial;
   logic [pcs_pkg::StepWidth-1:0] step_ff;
   logic [SW-1:0] lo, corr;
   logic strobe_ff, last_feature_ff;
   logic [pcs_pkg::IndexWidth-1:0] index_ff;
   logic [SW-1:0] corr_ff;

   assign plo   = product[MW-1:0];
   assign mag   = sxy_ff[MW-1] ? (~sxy_ff + 1'b1) : sxy_ff;
   assign trial = root_ff + bit_ff;
   assign lo    = root_ff[SW-1:0];
   assign corr  = sxy_ff[MW-1] ? (SW'(0) - lo) : (lo[SW-1] ? CorrMax : lo);
   assign take  = (state_ff == S_IDLE) && snap_valid;

   assign strobe        = strobe_ff;
   assign feature_index = index_ff;
   assign correlation   = corr_ff;
   assign last_feature  = last_feature_ff;

   always_comb begin
      if (features_in_use == '0) begin
         last_in = '0;
      end else if (features_in_use > CfgMax) begin
         last_in = pcs_pkg::IndexWidth'(pcs_pkg::NumFeatures - 1);
      end else begin
         last_in = pcs_pkg::IndexWidth'(features_in_use - 1'b1);
      end
   end

   always_comb begin
      mul_state = 1'b1;
      op_a      = '0;
      op_b      = '0;
      unique case (state_ff)
         S_YN: begin
            op_a = MW'(work_ff.count);
            op_b = MW'(work_ff.ysq);
         end
         S_YS: begin
            op_a = MW'($signed(work_ff.ysum));
            op_b = MW'($signed(work_ff.ysum));
         end
         S_XN: begin
            op_a = MW'(work_ff.count);
            op_b = MW'(work_ff.fsq[idx_ff]);
         end
         S_XS: begin
            op_a = MW'($signed(work_ff.fsum[idx_ff]));
            op_b = MW'($signed(work_ff.fsum[idx_ff]));
         end
         S_CN: begin
            op_a = MW'(work_ff.count);
            op_b = MW'($signed(work_ff.xsum[idx_ff]));
         end
         S_CS: begin
            op_a = MW'($signed(work_ff.fsum[idx_ff]));
            op_b = MW'($signed(work_ff.ysum));
         end
         S_DEN: begin
            op_a = $signed(sxx_ff);
            op_b = $signed(syy_ff);
         end
         S_NUM: begin
            op_a = $signed(mag);
            op_b = $signed(mag);
         end
         default: begin
            mul_state = 1'b0;
         end
      endcase
   end

   assign mul_go = mul_state && !wait_ff;

   pcs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (mul_go),
      .op_a    (op_a),
      .op_b    (op_b),
      .done    (mul_done),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wait_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (mul_go) begin
            wait_ff <= 1'b1;
         end
         if (mul_done) begin
            wait_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (snap_valid) begin
                  work_ff  <= snap;
                  idx_ff   <= '0;
                  last_ff  <= last_in;
                  state_ff <= S_YN;
               end
            end
            S_YN: begin
               if (mul_done) begin
                  t1_ff    <= plo;
                  state_ff <= S_YS;
               end
            end
            S_YS: begin
               if (mul_done) begin
                  syy_ff   <= t1_ff - plo;
                  state_ff <= S_XN;
               end
            end
            S_XN: begin
               if (mul_done) begin
                  t1_ff    <= plo;
                  state_ff <= S_XS;
               end
            end
            S_XS: begin
               if (mul_done) begin
                  sxx_ff   <= t1_ff - plo;
                  state_ff <= S_CN;
               end
            end
            S_CN: begin
               if (mul_done) begin
                  t1_ff    <= plo;
                  state_ff <= S_CS;
               end
            end
            S_CS: begin
               if (mul_done) begin
                  sxy_ff   <= t1_ff - plo;
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (sxx_ff == '0 || syy_ff == '0) begin
                  root_ff  <= '0;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_DEN;
               end
            end
            S_DEN: begin
               if (mul_done) begin
                  dsh_ff   <= {product[pcs_pkg::DenWidth-1:0], (QW-1)'(0)};
                  state_ff <= S_NUM;
               end
            end
            S_NUM: begin
               if (mul_done) begin
                  rem_ff   <= {product[pcs_pkg::DenWidth-1:0], (QW-1)'(0)};
                  quo_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (rem_ff >= dsh_ff) begin
                  rem_ff <= rem_ff - dsh_ff;
                  quo_ff <= {quo_ff[QW-2:0], 1'b1};
               end else begin
                  quo_ff <= {quo_ff[QW-2:0], 1'b0};
               end
               dsh_ff  <= dsh_ff >> 1;
               step_ff <= step_ff + 1'b1;
               if (step_ff == DivLast) begin
                  root_ff  <= '0;
                  bit_ff   <= {1'b1, (QW-1)'(0)};
                  step_ff  <= '0;
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (quo_ff >= trial) begin
                  quo_ff  <= quo_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               step_ff <= step_ff + 1'b1;
               if (step_ff == RootLast) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               strobe_ff       <= 1'b1;
               index_ff        <= idx_ff;
               corr_ff         <= corr;
               last_feature_ff <= (idx_ff == last_ff);
               if (idx_ff == last_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_XN;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
